// ===== hw/rtl/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants and types for the greedy box suppression block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

    localparam int MAX_KEPT  = 128;
    localparam int MAX_BOXES = 8192;

    localparam int IDX_W   = $clog2(MAX_KEPT);
    localparam int COUNT_W = $clog2(MAX_KEPT + 1);
    localparam int NUM_W   = $clog2(MAX_BOXES);

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int AREA_W  = 2 * SIZE_W;
    localparam int THR_W   = 9;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(115);

    // one stored kept box; left/top are two's complement
    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic [AREA_W-1:0]  area;
    } kept_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gbs_if.sv =====
// ----------------------------------------------------------------------------
// gbs interfaces
// Valid/ready channels: box input, result output and threshold write.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbs_box_if;
    logic                                valid;
    logic                                ready;
    logic                                start_frame;
    logic signed [gbs_pkg::COORD_W-1:0]  box_left;
    logic signed [gbs_pkg::COORD_W-1:0]  box_top;
    logic [gbs_pkg::SIZE_W-1:0]          box_width;
    logic [gbs_pkg::SIZE_W-1:0]          box_height;

    modport source (output valid, start_frame, box_left, box_top, box_width, box_height,
                    input ready);
    modport sink   (input valid, start_frame, box_left, box_top, box_width, box_height,
                    output ready);
endinterface

interface gbs_result_if;
    logic                          valid;
    logic                          ready;
    logic                          kept;
    logic [gbs_pkg::NUM_W-1:0]     box_number;
    logic [gbs_pkg::COUNT_W-1:0]   kept_total;
    logic                          store_full;

    modport source (output valid, kept, box_number, kept_total, store_full, input ready);
    modport sink   (input valid, kept, box_number, kept_total, store_full, output ready);
endinterface

interface gbs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [gbs_pkg::THR_W-1:0]   iou_threshold;

    modport source (output valid, iou_threshold, input ready);
    modport sink   (input valid, iou_threshold, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/greedy_box_suppression.sv =====
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy IoU suppression of score-ordered boxes against the kept set.
// ----------------------------------------------------------------------------
// Usage:
//   box    : one box per transfer, highest score first. start_frame=1 empties
//            the kept set and restarts box numbering before the box is checked.
//   result : one transfer per box: kept, box_number, kept_total, store_full.
//   cfg    : writes iou_threshold (fraction of 256); always ready, write only
//            between boxes.
// Flow: a box is compared with each stored box in turn through one shared
//   15x31 multiplier and a 128-entry store read one entry per pass. Each
//   stored box takes the steps read/overlap, intersection multiply, union,
//   threshold multiply and compare. The result is loaded once the checks
//   end (checking stops at the first suppressing box). box.ready rises with
//   that load, so a new box is only taken once the previous result is
//   loaded.
// Stall: the result sits in an output register; the next box is accepted and
//   processed meanwhile, and the block only waits when a second result is
//   ready before the first was taken.
// Reset: empty kept set, box numbering at zero, threshold 115. The store
//   itself is not cleared; only entries below the kept count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_box_suppression (
    input  wire logic     clk,
    input  wire logic     rst_n,
    gbs_cfg_if.sink       cfg,
    gbs_box_if.sink       box,
    gbs_result_if.source  result
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_AREA  = 3'd1;
    localparam logic [2:0] S_OVL   = 3'd2;
    localparam logic [2:0] S_INTER = 3'd3;
    localparam logic [2:0] S_UNION = 3'd4;
    localparam logic [2:0] S_TMUL  = 3'd5;
    localparam logic [2:0] S_CMP   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam int MUL_A_W = gbs_pkg::AREA_W + 1;
    localparam int MUL_B_W = gbs_pkg::SIZE_W;
    localparam int PROD_W  = gbs_pkg::THR_W + MUL_A_W;
    localparam int SCL_W   = gbs_pkg::AREA_W + 8;

    localparam logic [gbs_pkg::COUNT_W-1:0] MAX_COUNT = gbs_pkg::COUNT_W'(gbs_pkg::MAX_KEPT);
    localparam logic [gbs_pkg::NUM_W-1:0]   LAST_NUM  = gbs_pkg::NUM_W'(gbs_pkg::MAX_BOXES - 1);

    // control state
    logic [2:0]                    state_reg, state_next;
    logic [gbs_pkg::THR_W-1:0]     thr_reg;
    logic [gbs_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [gbs_pkg::NUM_W-1:0]     boxcnt_reg, boxcnt_next;
    logic [gbs_pkg::COUNT_W-1:0]   idx_reg, idx_next;
    logic                          keep_reg, keep_next;
    logic                          out_valid_reg, out_valid_next;

    // payload
    logic signed [gbs_pkg::COORD_W-1:0] left_reg, top_reg;
    logic [gbs_pkg::SIZE_W-1:0]    w_reg, h_reg;
    logic [gbs_pkg::NUM_W-1:0]     number_reg, number_next;
    logic [gbs_pkg::AREA_W-1:0]    area_reg;
    logic [gbs_pkg::SIZE_W-1:0]    iw_reg, ih_reg;
    logic [gbs_pkg::AREA_W-1:0]    earea_reg;
    logic [gbs_pkg::AREA_W-1:0]    inter_reg;
    logic [MUL_A_W-1:0]            uni_reg;
    logic [PROD_W-1:0]             prod_reg;
    gbs_pkg::kept_entry_t          rd_data_reg;

    logic                          out_kept_reg, out_full_reg;
    logic [gbs_pkg::NUM_W-1:0]     out_number_reg;
    logic [gbs_pkg::COUNT_W-1:0]   out_total_reg;

    // kept-box store
    gbs_pkg::kept_entry_t          mem [gbs_pkg::MAX_KEPT];
    logic                          rd_en, wr_en;
    logic [gbs_pkg::IDX_W-1:0]     rd_addr;
    gbs_pkg::kept_entry_t          wr_data;

    logic                          box_xfer, out_load, full;
    logic [gbs_pkg::COUNT_W-1:0]   idx_inc;

    // shared multiplier
    logic [MUL_A_W-1:0]            mul_a;
    logic [MUL_B_W-1:0]            mul_b;
    logic [MUL_A_W+MUL_B_W-1:0]    mul_p;

    // overlap of the current box with the entry just read
    logic signed [gbs_pkg::COORD_W-1:0] e_left, e_top, x_lo, y_lo;
    logic signed [gbs_pkg::COORD_W:0]   x_hi1, x_hi2, x_hi, y_hi1, y_hi2, y_hi;
    logic signed [gbs_pkg::COORD_W+1:0] x_diff, y_diff;
    logic [gbs_pkg::SIZE_W-1:0]    iw, ih;
    logic                          suppress;

    assign box.ready  = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign box_xfer   = box.valid && box.ready;
    assign idx_inc    = idx_reg + 1'b1;
    assign full       = (count_reg == MAX_COUNT);
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    assign result.valid      = out_valid_reg;
    assign result.kept       = out_kept_reg;
    assign result.box_number = out_number_reg;
    assign result.kept_total = out_total_reg;
    assign result.store_full = out_full_reg;

    always_comb
    begin
        case (state_reg)
            S_AREA:
            begin
                mul_a = MUL_A_W'(w_reg);
                mul_b = h_reg;
            end
            S_INTER:
            begin
                mul_a = MUL_A_W'(iw_reg);
                mul_b = ih_reg;
            end
            S_TMUL:
            begin
                mul_a = uni_reg;
                mul_b = MUL_B_W'(thr_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign e_left = $signed(rd_data_reg.left);
    assign e_top  = $signed(rd_data_reg.top);

    always_comb
    begin
        x_lo   = (left_reg > e_left) ? left_reg : e_left;
        x_hi1  = (gbs_pkg::COORD_W+1)'(left_reg) + $signed({2'b00, w_reg});
        x_hi2  = (gbs_pkg::COORD_W+1)'(e_left) + $signed({2'b00, rd_data_reg.width});
        x_hi   = (x_hi1 < x_hi2) ? x_hi1 : x_hi2;
        x_diff = (gbs_pkg::COORD_W+2)'(x_hi) - (gbs_pkg::COORD_W+2)'(x_lo);
        iw     = (x_diff > 0) ? x_diff[gbs_pkg::SIZE_W-1:0] : '0;

        y_lo   = (top_reg > e_top) ? top_reg : e_top;
        y_hi1  = (gbs_pkg::COORD_W+1)'(top_reg) + $signed({2'b00, h_reg});
        y_hi2  = (gbs_pkg::COORD_W+1)'(e_top) + $signed({2'b00, rd_data_reg.height});
        y_hi   = (y_hi1 < y_hi2) ? y_hi1 : y_hi2;
        y_diff = (gbs_pkg::COORD_W+2)'(y_hi) - (gbs_pkg::COORD_W+2)'(y_lo);
        ih     = (y_diff > 0) ? y_diff[gbs_pkg::SIZE_W-1:0] : '0;
    end

    // intersection*256 > threshold*union
    assign suppress = PROD_W'({inter_reg, 8'h00}) > prod_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        boxcnt_next    = boxcnt_reg;
        idx_next       = idx_reg;
        keep_next      = keep_reg;
        number_next    = number_reg;
        out_valid_next = out_valid_reg && !result.ready;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (box_xfer)
                begin
                    keep_next  = 1'b1;
                    state_next = S_AREA;
                    if (box.start_frame)
                    begin
                        count_next  = '0;
                        number_next = '0;
                        boxcnt_next = gbs_pkg::NUM_W'(1);
                    end
                    else
                    begin
                        number_next = boxcnt_reg;
                        if (boxcnt_reg != LAST_NUM)
                            boxcnt_next = boxcnt_reg + 1'b1;
                    end
                end
            end
            S_AREA:
            begin
                idx_next = '0;
                if (count_reg == '0)
                    state_next = S_DONE;
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_OVL;
                end
            end
            S_OVL:   state_next = S_INTER;
            S_INTER: state_next = S_UNION;
            S_UNION: state_next = S_TMUL;
            S_TMUL:  state_next = S_CMP;
            S_CMP:
            begin
                idx_next = idx_inc;
                if (suppress)
                begin
                    keep_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (idx_inc < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[gbs_pkg::IDX_W-1:0];
                    state_next = S_OVL;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (keep_reg && !full)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign wr_data = '{left:   left_reg,
                       top:    top_reg,
                       width:  w_reg,
                       height: h_reg,
                       area:   area_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[gbs_pkg::IDX_W-1:0]] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= gbs_pkg::THR_RESET;
            count_reg     <= '0;
            boxcnt_reg    <= '0;
            idx_reg       <= '0;
            keep_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            boxcnt_reg    <= boxcnt_next;
            idx_reg       <= idx_next;
            keep_reg      <= keep_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                thr_reg <= cfg.iou_threshold;
        end
    end

    always_ff @(posedge clk)
    begin
        number_reg <= number_next;
        if (box_xfer)
        begin
            left_reg <= box.box_left;
            top_reg  <= box.box_top;
            w_reg    <= box.box_width;
            h_reg    <= box.box_height;
        end
        if (state_reg == S_AREA)
            area_reg <= mul_p[gbs_pkg::AREA_W-1:0];
        if (state_reg == S_OVL)
        begin
            iw_reg    <= iw;
            ih_reg    <= ih;
            earea_reg <= rd_data_reg.area;
        end
        if (state_reg == S_INTER)
            inter_reg <= mul_p[gbs_pkg::AREA_W-1:0];
        if (state_reg == S_UNION)
            uni_reg <= MUL_A_W'(area_reg) + MUL_A_W'(earea_reg) - MUL_A_W'(inter_reg);
        if (state_reg == S_TMUL)
            prod_reg <= mul_p[PROD_W-1:0];
        if (out_load)
        begin
            out_kept_reg   <= keep_reg;
            out_full_reg   <= keep_reg && full;
            out_number_reg <= number_reg;
            out_total_reg  <= (keep_reg && !full) ? count_reg + 1'b1 : count_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gbs_checker.sv =====
// ----------------------------------------------------------------------------
// gbs_checker
// Port-level checks for greedy_box_suppression, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          box_valid,
    input wire logic                          box_ready,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic                          res_kept,
    input wire logic [gbs_pkg::NUM_W-1:0]     res_box_number,
    input wire logic [gbs_pkg::COUNT_W-1:0]   res_kept_total,
    input wire logic                          res_store_full
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kept)
            && $stable(res_box_number) && $stable(res_kept_total)
            && $stable(res_store_full))
        else $error("result changed while stalled");

    // one box at a time: busy right after a box transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && box_ready |=> !box_ready)
        else $error("box accepted while previous box in progress");

    // overflow only for a kept box, and only with a full store
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_store_full |->
            res_kept && (res_kept_total == gbs_pkg::COUNT_W'(gbs_pkg::MAX_KEPT)))
        else $error("store_full without kept box or full store");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_kept |-> !res_store_full)
        else $error("suppressed box flagged store_full");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .box_valid      (box.valid),
    .box_ready      (box.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_kept       (result.kept),
    .res_box_number (result.box_number),
    .res_kept_total (result.kept_total),
    .res_store_full (result.store_full)
);

`default_nettype wire
